[src/qrs_pkg.sv]
`default_nettype none
package qrs_pkg;
   localparam int FRACTION_BITS_DEF = 16;
   localparam int COEF_WIDTH_DEF = 16;
   localparam int ROOT_WIDTH = 33;
   localparam int STATUS_WIDTH = 2;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_NONE = 2'd0,
      ST_ONE  = 2'd1,
      ST_TWO  = 2'd2,
      ST_AZERO = 2'd3
   } status_type;
endpackage
`default_nettype wire

[src/qrs_front.sv]
`default_nettype none
module qrs_front #(
   parameter int CW = 16,
   parameter int FB = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   adv,
   input  wire logic                   in_valid,
   input  wire logic signed [CW-1:0]   coef_a,
   input  wire logic signed [CW-1:0]   coef_b,
   input  wire logic signed [CW-1:0]   coef_c,
   output logic                        out_valid,
   output qrs_pkg::status_type         out_status,
   output logic [2*CW+1:0]             out_disc,
   output logic signed [CW+FB:0]       out_nb,
   output logic signed [CW:0]          out_den
);
   import qrs_pkg::*;
   localparam int DW = 2*CW + 3;

   logic                      v1_ff, v2_ff;
   logic signed [CW-1:0]      a1_ff, b1_ff;
   logic signed [2*CW-1:0]    bb_ff, ac_ff;
   logic signed [DW-1:0]      disc;
   status_type                st_in, st_ff;
   logic [DW-2:0]             disc_ff;
   logic signed [CW+FB:0]     nb_ff;
   logic signed [CW:0]        den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff <= coef_a;
         b1_ff <= coef_b;
         bb_ff <= coef_b * coef_b;
         ac_ff <= coef_a * coef_c;
      end
   end

   always_comb begin
      disc = DW'(bb_ff) - (DW'(ac_ff) <<< 2);
      if (a1_ff == '0) begin
         st_in = ST_AZERO;
      end else if (disc[DW-1]) begin
         st_in = ST_NONE;
      end else if (disc == '0) begin
         st_in = ST_ONE;
      end else begin
         st_in = ST_TWO;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff   <= st_in;
         disc_ff <= (st_in == ST_TWO) ? disc[DW-2:0] : '0;
         nb_ff   <= -((CW+FB+1)'(b1_ff) <<< FB);
         den_ff  <= (CW+1)'(a1_ff) <<< 1;
      end
   end

   assign out_valid  = v2_ff;
   assign out_status = st_ff;
   assign out_disc   = disc_ff;
   assign out_nb     = nb_ff;
   assign out_den    = den_ff;
endmodule
`default_nettype wire

[src/qrs_sqrt_pipe.sv]
`default_nettype none
module qrs_sqrt_pipe #(
   parameter int XW = 66,
   parameter int SIDE_W = 8,
   localparam int SW = (XW + 1) / 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              adv,
   input  wire logic              in_valid,
   input  wire logic [XW-1:0]     in_x,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [SW-1:0]          out_root,
   output logic [SIDE_W-1:0]      out_side
);
   localparam int RW = SW + 3;

   logic              v_ff    [0:SW];
   logic [2*SW-1:0]   x_ff    [0:SW];
   logic [RW-1:0]     rem_ff  [0:SW];
   logic [SW-1:0]     root_ff [0:SW];
   logic [SIDE_W-1:0] side_ff [0:SW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= (2*SW)'(in_x);
         rem_ff[0]  <= '0;
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < SW; i++) begin : g_step
      logic [RW-1:0] shifted, trial;
      logic          fits;
      always_comb begin
         shifted = {rem_ff[i][RW-3:0], x_ff[i][2*SW-1-2*i -: 2]};
         trial   = {1'b0, root_ff[i], 2'b01};
         fits    = shifted >= trial;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[i+1]    <= x_ff[i];
            side_ff[i+1] <= side_ff[i];
            rem_ff[i+1]  <= fits ? shifted - trial : shifted;
            root_ff[i+1] <= {root_ff[i][SW-2:0], fits};
         end
      end
   end

   assign out_valid = v_ff[SW];
   assign out_root  = root_ff[SW];
   assign out_side  = side_ff[SW];
endmodule
`default_nettype wire

[src/qrs_div_pipe.sv]
`default_nettype none
module qrs_div_pipe #(
   parameter int NW = 35,
   parameter int DW = 17,
   parameter int SIDE_W = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               adv,
   input  wire logic               in_valid,
   input  wire logic signed [NW-1:0] in_num,
   input  wire logic signed [DW-1:0] in_den,
   input  wire logic [SIDE_W-1:0]  in_side,
   output logic                    out_valid,
   output logic [NW-1:0]           out_quot,
   output logic                    out_neg,
   output logic [SIDE_W-1:0]       out_side
);
   localparam int RW = DW + 1;

   logic              v_ff    [0:NW];
   logic [NW-1:0]     n_ff    [0:NW];
   logic [NW-1:0]     q_ff    [0:NW];
   logic [RW-1:0]     rem_ff  [0:NW];
   logic [DW-1:0]     d_ff    [0:NW];
   logic              neg_ff  [0:NW];
   logic [SIDE_W-1:0] side_ff [0:NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n_ff[0]    <= in_num[NW-1] ? NW'(-in_num) : NW'(in_num);
         d_ff[0]    <= in_den[DW-1] ? DW'(-in_den) : DW'(in_den);
         neg_ff[0]  <= in_num[NW-1] ^ in_den[DW-1];
         q_ff[0]    <= '0;
         rem_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar i = 0; i < NW; i++) begin : g_step
      logic [RW-1:0] shifted;
      logic          fits;
      always_comb begin
         shifted = {rem_ff[i][RW-2:0], n_ff[i][NW-1]};
         fits    = shifted >= RW'(d_ff[i]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (adv) begin
            v_ff[i+1] <= v_ff[i];
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            n_ff[i+1]    <= n_ff[i] << 1;
            d_ff[i+1]    <= d_ff[i];
            neg_ff[i+1]  <= neg_ff[i];
            side_ff[i+1] <= side_ff[i];
            rem_ff[i+1]  <= fits ? shifted - RW'(d_ff[i]) : shifted;
            q_ff[i+1]    <= {q_ff[i][NW-2:0], fits};
         end
      end
   end

   assign out_valid = v_ff[NW];
   assign out_quot  = q_ff[NW];
   assign out_neg   = neg_ff[NW];
   assign out_side  = side_ff[NW];
endmodule
`default_nettype wire

[src/quadratic_root_solver_top.sv]
// Throughput: one coefficient set per cycle; the bit-serial square root and the two
// restoring dividers are unrolled into one register stage per result bit.
// A stalled result register holds the whole pipeline in place.
// Reset is synchronous and active high; it clears every valid bit.
`default_nettype none
module quadratic_root_solver_top #(
   parameter int FRACTION_BITS = qrs_pkg::FRACTION_BITS_DEF,
   parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // coef_a, coef_b, coef_c, zero fill
   input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // root_status, first_root, second_root, zero fill
   output logic [71:0] rsp_tdata
);
   import qrs_pkg::*;
   localparam int CW = COEF_WIDTH;
   localparam int FB = FRACTION_BITS;
   localparam int DUW = 2*CW + 2;
   localparam int XW = DUW + 2*FB;
   localparam int SW = (XW + 1) / 2;
   localparam int NBW = CW + FB + 1;
   localparam int NW = ((NBW > SW + 1) ? NBW : SW + 1) + 1;
   localparam int EW = ((NW + 1) > (ROOT_WIDTH + 1)) ? NW + 1 : ROOT_WIDTH + 1;
   localparam int SIDE_W = STATUS_WIDTH + NBW + CW + 1;

   logic                    adv;
   logic                    f_valid;
   status_type              f_status;
   logic [DUW-1:0]          f_disc;
   logic signed [NBW-1:0]   f_nb;
   logic signed [CW:0]      f_den;
   logic                    s_valid;
   logic [SW-1:0]           s_root;
   logic [SIDE_W-1:0]       s_side;
   logic signed [NBW-1:0]   s_nb;
   logic signed [CW:0]      s_den;
   logic [STATUS_WIDTH-1:0] s_status;
   logic                    n_valid_ff;
   logic signed [NW-1:0]    n1_ff, n2_ff;
   logic signed [CW:0]      den_ff;
   logic [STATUS_WIDTH-1:0] st_ff;
   logic                    d1_valid, d2_valid;
   logic [NW-1:0]           q1, q2;
   logic                    neg1, neg2;
   logic [STATUS_WIDTH-1:0] st1, st2;
   logic signed [ROOT_WIDTH-1:0] r1, r2;
   logic                    rsp_tvalid_ff;
   logic [71:0]             rsp_tdata_ff;

   function automatic logic signed [ROOT_WIDTH-1:0] clamp_root(
         input logic [NW-1:0] q, input logic neg);
      logic signed [EW-1:0] v;
      logic signed [EW-1:0] hi;
      logic signed [EW-1:0] lo;
      begin
         v  = neg ? -EW'(q) : EW'(q);
         hi = EW'({1'b0, {(ROOT_WIDTH-1){1'b1}}});
         lo = -hi - EW'(1);
         if (v > hi) begin
            clamp_root = hi[ROOT_WIDTH-1:0];
         end else if (v < lo) begin
            clamp_root = lo[ROOT_WIDTH-1:0];
         end else begin
            clamp_root = v[ROOT_WIDTH-1:0];
         end
      end
   endfunction

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   qrs_front #(.CW(CW), .FB(FB)) u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid),
      .coef_a(req_tdata[CW-1:0]),
      .coef_b(req_tdata[2*CW-1:CW]),
      .coef_c(req_tdata[3*CW-1:2*CW]),
      .out_valid(f_valid), .out_status(f_status), .out_disc(f_disc),
      .out_nb(f_nb), .out_den(f_den)
   );

   qrs_sqrt_pipe #(.XW(XW), .SIDE_W(SIDE_W)) u_sqrt (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(f_valid),
      .in_x({f_disc, {(2*FB){1'b0}}}),
      .in_side({f_status, f_nb, f_den}),
      .out_valid(s_valid), .out_root(s_root), .out_side(s_side)
   );

   assign {s_status, s_nb, s_den} = s_side;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else if (adv) begin
         n_valid_ff <= s_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         n1_ff  <= NW'(s_nb) + NW'(s_root);
         n2_ff  <= NW'(s_nb) - NW'(s_root);
         den_ff <= s_den;
         st_ff  <= s_status;
      end
   end

   qrs_div_pipe #(.NW(NW), .DW(CW+1), .SIDE_W(STATUS_WIDTH)) u_div_first (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(n_valid_ff), .in_num(n1_ff), .in_den(den_ff), .in_side(st_ff),
      .out_valid(d1_valid), .out_quot(q1), .out_neg(neg1), .out_side(st1)
   );

   qrs_div_pipe #(.NW(NW), .DW(CW+1), .SIDE_W(STATUS_WIDTH)) u_div_second (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(n_valid_ff), .in_num(n2_ff), .in_den(den_ff), .in_side(st_ff),
      .out_valid(d2_valid), .out_quot(q2), .out_neg(neg2), .out_side(st2)
   );

   always_comb begin
      r1 = (st1 == ST_ONE || st1 == ST_TWO) ? clamp_root(q1, neg1) : '0;
      r2 = (st2 == ST_ONE || st2 == ST_TWO) ? clamp_root(q2, neg2) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= d1_valid && d2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= 72'({r2, r1, st1});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
endmodule
`default_nettype wire

[src/qrs_checker.sv]
`default_nettype none
module qrs_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [71:0] rsp_tdata
);
   import qrs_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result transfer changed");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty result register");

   a_noroot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == ST_NONE || rsp_tdata[1:0] == ST_AZERO)
      |-> rsp_tdata[67:2] == '0)
      else $error("roots not zero without real roots");

   a_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ST_ONE |-> rsp_tdata[34:2] == rsp_tdata[67:35])
      else $error("single root differs between fields");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:68] == '0)
      else $error("fill bits not zero");
endmodule

bind quadratic_root_solver_top qrs_checker u_qrs_checker (
   .clock(clock), .reset(reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
